// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted priority queue
// Holds the entry widths, queue depth, operation and status codes, and the
// control word that is broadcast to every cell of the chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int DEPTH  = 128;
    localparam int TAG_W  = 16;
    localparam int PRIO_W = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int KIND_W   = 1;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 8;

    localparam logic [KIND_W-1:0] KIND_ENQ = 1'b0;
    localparam logic [KIND_W-1:0] KIND_DEQ = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef logic [TAG_W-1:0]         tag_t;
    typedef logic signed [PRIO_W-1:0] prio_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // Operation broadcast to all cells in the cycle it is applied.
    typedef struct packed {
        logic  enq;
        logic  deq;
        tag_t  tag;
        prio_t prio;
    } spq_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: bounded priority queue kept in service order
// The result of an accepted transfer is registered and presented in the next cycle.
// Throughput: one operation per cycle while the result port is not stalled, enqueue or dequeue in any mix.
// Reset clears the entry count and the result valid flag; the entry storage
// and the result fields are not cleared, since only slots below the count
// are ever read and the result fields are only looked at while valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire [spq_pkg::KIND_W-1:0]      kind,
    input  wire [15:0]                     payload,
    input  wire signed [15:0]              priority_req,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [spq_pkg::STATUS_W-1:0]   status,
    output logic [15:0]                    out_payload,
    output logic signed [15:0]             out_priority,
    output logic [spq_pkg::OCC_W-1:0]      occupancy
);
    import spq_pkg::*;

    // The queue is a chain of DEPTH cells, slot 0 at the front. Entries are
    // held sorted by priority, highest first. Each operation is broadcast to
    // all cells at once and every cell settles its next content from its own
    // entry and those of its two neighbours, so an insert or a removal updates
    // the whole chain at once, wherever in the chain it lands.

    cnt_t       count_reg;
    cnt_t       count_next;
    spq_ctrl_t  ctrl;
    logic       in_accept;
    logic       is_full;
    logic       is_empty;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [STATUS_W-1:0]   status_reg;
    logic [STATUS_W-1:0]   status_next;
    tag_t                  out_tag_reg;
    tag_t                  out_tag_next;
    prio_t                 out_prio_reg;
    prio_t                 out_prio_next;
    logic [OCC_W-1:0]      occ_reg;
    logic [OCC_W-1:0]      occ_next;

    tag_t  cell_tag  [DEPTH];
    prio_t cell_prio [DEPTH];
    logic  cell_keep [DEPTH];
    logic  cell_occ  [DEPTH];

    // A new transfer is taken whenever the output register is free or is
    // being emptied in this same cycle.
    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign is_full  = (count_reg == cnt_t'(DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        ctrl.enq  = in_accept && (kind == KIND_ENQ) && !is_full;
        ctrl.deq  = in_accept && (kind == KIND_DEQ) && !is_empty;
        ctrl.tag  = payload[TAG_W-1:0];
        ctrl.prio = priority_req[PRIO_W-1:0];
    end

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            tag_t  l_tag;
            prio_t l_prio;
            logic  l_keep;
            tag_t  r_tag;
            prio_t r_prio;

            assign cell_occ[gi] = (count_reg > cnt_t'(gi));

            if (gi == 0)
            begin : g_front
                // The front cell behaves as if an entry that always wins sat
                // ahead of it, so it takes the new entry when it gives way.
                assign l_keep = 1'b1;
                assign l_tag  = ctrl.tag;
                assign l_prio = ctrl.prio;
            end
            else
            begin : g_mid
                assign l_keep = cell_keep[gi-1];
                assign l_tag  = cell_tag[gi-1];
                assign l_prio = cell_prio[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_back
                // Nothing lies behind the last cell; what it takes on a
                // removal is beyond the count and never read.
                assign r_tag  = '0;
                assign r_prio = '0;
            end
            else
            begin : g_inner
                assign r_tag  = cell_tag[gi+1];
                assign r_prio = cell_prio[gi+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (cell_occ[gi]),
                .left_keep  (l_keep),
                .left_tag   (l_tag),
                .left_prio  (l_prio),
                .right_tag  (r_tag),
                .right_prio (r_prio),
                .tag        (cell_tag[gi]),
                .prio       (cell_prio[gi]),
                .keep       (cell_keep[gi])
            );
        end
    endgenerate

    // ------------------------------------------------------------------
    // Count and result
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.enq)
        begin
            count_next = count_reg + cnt_t'(1);
        end
        else if (ctrl.deq)
        begin
            count_next = count_reg - cnt_t'(1);
        end
    end

    always_comb
    begin
        status_next   = ST_OK;
        out_tag_next  = '0;
        out_prio_next = '0;
        if (kind == KIND_ENQ)
        begin
            if (is_full)
            begin
                status_next = ST_FULL;
            end
        end
        else
        begin
            if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                // The front cell holds the highest priority entry.
                out_tag_next  = cell_tag[0];
                out_prio_next = cell_prio[0];
            end
        end
        occ_next = count_next[OCC_W-1:0];
    end

    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            status_reg   <= status_next;
            out_tag_reg  <= out_tag_next;
            out_prio_reg <= out_prio_next;
            occ_reg      <= occ_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_payload  = out_tag_reg;
    assign out_priority = out_prio_reg;
    assign occupancy    = occ_reg;

endmodule

`default_nettype wire

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one storage slot of the sorted priority queue
// Holds a single entry. On an insert it keeps its entry, takes the new one or
// takes its left neighbour's; on a removal it takes its right neighbour's.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
    input  wire                    clk,
    input  wire spq_pkg::spq_ctrl_t ctrl,
    input  wire                    occupied,
    input  wire                    left_keep,
    input  wire spq_pkg::tag_t     left_tag,
    input  wire spq_pkg::prio_t    left_prio,
    input  wire spq_pkg::tag_t     right_tag,
    input  wire spq_pkg::prio_t    right_prio,
    output spq_pkg::tag_t          tag,
    output spq_pkg::prio_t         prio,
    output logic                   keep
);
    import spq_pkg::*;

    tag_t  tag_reg;
    prio_t prio_reg;
    tag_t  tag_next;
    prio_t prio_next;

    // An occupied slot whose priority is at least the new one stays in front
    // of the new entry, which keeps equal priorities in arrival order.
    assign keep = occupied && (prio_reg >= ctrl.prio);

    always_comb
    begin
        tag_next  = tag_reg;
        prio_next = prio_reg;
        if (ctrl.enq)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    tag_next  = ctrl.tag;
                    prio_next = ctrl.prio;
                end
                else
                begin
                    tag_next  = left_tag;
                    prio_next = left_prio;
                end
            end
        end
        else if (ctrl.deq)
        begin
            tag_next  = right_tag;
            prio_next = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg  <= tag_next;
        prio_reg <= prio_next;
    end

    assign tag  = tag_reg;
    assign prio = prio_reg;

endmodule

`default_nettype wire

// File: rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the result channel and checks that status, payload and occupancy
// agree with one another and with the depth of the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_checker (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            in_valid,
    input  wire                            in_stall,
    input  wire                            out_valid,
    input  wire                            out_stall,
    input  wire [spq_pkg::STATUS_W-1:0]    status,
    input  wire [15:0]                     out_payload,
    input  wire signed [15:0]              out_priority,
    input  wire [spq_pkg::OCC_W-1:0]       occupancy
);
    import spq_pkg::*;

    // A stalled result stays on the port until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(occupancy))
        else $error("result changed while stalled");

    // A dequeue on an empty queue leaves it empty and carries no entry.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |->
            (occupancy == '0) && (out_payload == '0) && (out_priority == '0))
        else $error("empty status with data or occupancy");

    // A rejected enqueue happens only with every slot in use.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |->
            (occupancy == OCC_W'(DEPTH)) && (out_payload == '0))
        else $error("full status below depth");

    // Back-to-back transfers never move the occupancy by more than one.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && in_valid && !in_stall ##1 out_valid |->
            (occupancy == $past(occupancy)) ||
            (occupancy == $past(occupancy) + OCC_W'(1)) ||
            (occupancy == $past(occupancy) - OCC_W'(1)))
        else $error("occupancy jumped");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_payload  (out_payload),
    .out_priority (out_priority),
    .occupancy    (occupancy)
);

`default_nettype wire
